/* hw/rtl/rdc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdc_pkg
// shared types, constants and helper functions of the rtc datetime bcd codec
// ----------------------------------------------------------------------------
package rdc_pkg;

    // operation codes
    localparam logic OP_DECODE = 1'b0;
    localparam logic OP_ENCODE = 1'b1;

    // register byte masks
    localparam logic [7:0] SEC_MASK  = 8'h7f;
    localparam logic [7:0] MIN_MASK  = 8'h7f;
    localparam logic [7:0] HOUR_MASK = 8'h3f;
    localparam logic [7:0] DAY_MASK  = 8'h3f;
    localparam logic [7:0] WDAY_MASK = 8'h07;
    localparam logic [7:0] MON_MASK  = 8'h1f;
    localparam int         OSC_STOP_BIT = 7;

    // calendar limits
    localparam logic [11:0] YEAR_BASE = 12'd2000;
    localparam logic [11:0] YEAR_MAX  = 12'd2099;
    localparam logic [7:0]  MON_MAX   = 8'd12;
    localparam logic [7:0]  WDAY_MAX  = 8'd6;
    localparam logic [7:0]  HOUR_MAX  = 8'd23;
    localparam logic [7:0]  MIN_MAX   = 8'd59;
    localparam logic [7:0]  SEC_MAX   = 8'd59;

    // datetime after the unpack stage
    typedef struct packed {
        logic        op;
        logic        clock_ok;
        logic [11:0] year;
        logic [7:0]  month;
        logic [7:0]  day;
        logic [7:0]  weekday;
        logic [7:0]  hour;
        logic [7:0]  minute;
        logic [7:0]  second;
    } rdc_dt_t;

    // datetime after the check stage
    typedef struct packed {
        rdc_dt_t     dt;
        logic        ok;
        logic [6:0]  yy;
        logic [7:0]  zsum;
    } rdc_chk_t;

    // bcd byte to decimal, high*10 + low even for bad digits
    function automatic logic [7:0] from_bcd(input logic [7:0] b);
        logic [7:0] hi8;
        logic [7:0] lo8;
        hi8 = {4'b0000, b[7:4]};
        lo8 = {4'b0000, b[3:0]};
        return (hi8 << 3) + (hi8 << 1) + lo8;
    endfunction

    // decimal 0..99 to bcd, tens by reciprocal multiply
    function automatic logic [7:0] to_bcd(input logic [6:0] x);
        logic [13:0] prod;
        logic [3:0]  tens;
        logic [6:0]  ones;
        prod = {7'b0, x} * 14'd103;
        tens = prod[13:10];
        ones = x - 7'({3'b000, tens} * 7'd10);
        return {tens, ones[3:0]};
    endfunction

    // days in month 1..12, zero outside
    function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
        logic [4:0] d;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    d = 5'd30;
            4'd2:                                       d = leap ? 5'd29 : 5'd28;
            default:                                    d = 5'd0;
        endcase
        return d;
    endfunction

    // zeller month term (13*(m+1))/5 mod 7, jan and feb as months 13 and 14
    function automatic logic [2:0] zeller_month(input logic [3:0] m);
        logic [2:0] t;
        case (m)
            4'd1:    t = 3'd1;
            4'd2:    t = 3'd4;
            4'd3:    t = 3'd3;
            4'd4:    t = 3'd6;
            4'd5:    t = 3'd1;
            4'd6:    t = 3'd4;
            4'd7:    t = 3'd6;
            4'd8:    t = 3'd2;
            4'd9:    t = 3'd5;
            4'd10:   t = 3'd0;
            4'd11:   t = 3'd3;
            4'd12:   t = 3'd5;
            default: t = 3'd0;
        endcase
        return t;
    endfunction

    // 8-bit value mod 7 by octal digit folding
    function automatic logic [2:0] mod7(input logic [7:0] x);
        logic [4:0] s;
        logic [3:0] t;
        s = {3'b000, x[7:6]} + {2'b00, x[5:3]} + {2'b00, x[2:0]};
        t = {2'b00, s[4:3]} + {1'b0, s[2:0]};
        return (t >= 4'd7) ? 3'(t - 4'd7) : t[2:0];
    endfunction

endpackage

/* hw/rtl/rdc_unpack.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdc_unpack
// first stage: bcd decode of the register bytes or pass of the decimal input
// ----------------------------------------------------------------------------
module rdc_unpack
    import rdc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        op,
    input  logic [11:0] year_in,
    input  logic [7:0]  month_in,
    input  logic [7:0]  day_in,
    input  logic [7:0]  weekday_in,
    input  logic [7:0]  hour_in,
    input  logic [7:0]  minute_in,
    input  logic [7:0]  second_in,
    output logic        dn_valid,
    input  logic        dn_ready,
    output rdc_dt_t     dn_data
);

    logic    valid_reg;
    rdc_dt_t data_reg;
    rdc_dt_t data_next;

    // select decoded or raw fields
    always_comb
    begin
        data_next.op = op;
        if (op == OP_DECODE)
        begin
            data_next.clock_ok = ~second_in[OSC_STOP_BIT];
            data_next.year     = YEAR_BASE + {4'b0000, from_bcd(year_in[7:0])};
            data_next.month    = from_bcd(month_in & MON_MASK);
            data_next.day      = from_bcd(day_in & DAY_MASK);
            data_next.weekday  = from_bcd(weekday_in & WDAY_MASK);
            data_next.hour     = from_bcd(hour_in & HOUR_MASK);
            data_next.minute   = from_bcd(minute_in & MIN_MASK);
            data_next.second   = from_bcd(second_in & SEC_MASK);
        end
        else
        begin
            data_next.clock_ok = 1'b0;
            data_next.year     = year_in;
            data_next.month    = month_in;
            data_next.day      = day_in;
            data_next.weekday  = weekday_in;
            data_next.hour     = hour_in;
            data_next.minute   = minute_in;
            data_next.second   = second_in;
        end
    end

    assign in_ready = ~valid_reg | dn_ready;

    // stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            data_reg <= data_next;
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

endmodule

/* hw/rtl/rdc_check.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdc_check
// second stage: range, month length and leap checks, zeller weekday sum
// ----------------------------------------------------------------------------
module rdc_check
    import rdc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     up_valid,
    output logic     up_ready,
    input  rdc_dt_t  up_data,
    output logic     dn_valid,
    input  logic     dn_ready,
    output rdc_chk_t dn_data
);

    logic       valid_reg;
    rdc_chk_t   data_reg;
    rdc_chk_t   data_next;

    logic        year_ok;
    logic        month_ok;
    logic        day_ok;
    logic        misc_ok;
    logic        leap;
    logic [11:0] year_off;
    logic [6:0]  yy;
    logic [4:0]  mdays;
    logic        early;
    logic [6:0]  k;
    logic        jterm;

    // validity of the datetime
    always_comb
    begin
        year_off = up_data.year - YEAR_BASE;
        yy       = year_off[6:0];
        year_ok  = (up_data.year >= YEAR_BASE) && (up_data.year <= YEAR_MAX);
        leap     = (yy[1:0] == 2'b00);
        month_ok = (up_data.month >= 8'd1) && (up_data.month <= MON_MAX);
        mdays    = month_days(up_data.month[3:0], leap);
        day_ok   = (up_data.day >= 8'd1) && (up_data.day <= {3'b000, mdays});
        misc_ok  = (up_data.weekday <= WDAY_MAX) && (up_data.hour <= HOUR_MAX)
                   && (up_data.minute <= MIN_MAX) && (up_data.second <= SEC_MAX);
    end

    // zeller sum; century term mod 7 is 0 for 20xx and 1 for 1999
    always_comb
    begin
        early = (up_data.month[3:0] == 4'd1) || (up_data.month[3:0] == 4'd2);
        if (early)
            k = (yy == 7'd0) ? 7'd99 : yy - 7'd1;
        else
            k = yy;
        jterm = early && (yy == 7'd0);
        data_next.zsum = {3'b000, up_data.day[4:0]}
                         + {5'b00000, zeller_month(up_data.month[3:0])}
                         + {1'b0, k} + {3'b000, k[6:2]} + {7'b0000000, jterm};
        data_next.dt = up_data;
        data_next.ok = year_ok && month_ok && day_ok && misc_ok;
        data_next.yy = yy;
    end

    assign up_ready = ~valid_reg | dn_ready;

    // stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (up_ready)
            valid_reg <= up_valid;
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
            data_reg <= data_next;
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

endmodule

/* hw/rtl/rdc_pack.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdc_pack
// third stage: weekday reduction, bcd encode and output register
// ----------------------------------------------------------------------------
module rdc_pack
    import rdc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        up_valid,
    output logic        up_ready,
    input  rdc_chk_t    up_data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [11:0] year_out,
    output logic [7:0]  month_out,
    output logic [7:0]  day_out,
    output logic [7:0]  weekday_out,
    output logic [7:0]  hour_out,
    output logic [7:0]  minute_out,
    output logic [7:0]  second_out,
    output logic        clock_ok,
    output logic        valid_res
);

    logic        valid_reg;
    logic [11:0] year_reg,    year_next;
    logic [7:0]  month_reg,   month_next;
    logic [7:0]  day_reg,     day_next;
    logic [7:0]  weekday_reg, weekday_next;
    logic [7:0]  hour_reg,    hour_next;
    logic [7:0]  minute_reg,  minute_next;
    logic [7:0]  second_reg,  second_next;
    logic        clock_ok_reg, clock_ok_next;
    logic        vres_reg,    vres_next;
    logic [2:0]  h7;
    logic [2:0]  wday;

    // result fields per operation
    always_comb
    begin
        h7   = mod7(up_data.zsum);
        wday = (h7 == 3'd0) ? 3'd6 : h7 - 3'd1;
        if (up_data.dt.op == OP_DECODE)
        begin
            year_next     = up_data.dt.year;
            month_next    = up_data.dt.month;
            day_next      = up_data.dt.day;
            weekday_next  = up_data.dt.weekday;
            hour_next     = up_data.dt.hour;
            minute_next   = up_data.dt.minute;
            second_next   = up_data.dt.second;
            clock_ok_next = up_data.dt.clock_ok;
            vres_next     = up_data.ok;
        end
        else if (up_data.ok)
        begin
            year_next     = {4'b0000, to_bcd(up_data.yy)};
            month_next    = to_bcd(up_data.dt.month[6:0]);
            day_next      = to_bcd(up_data.dt.day[6:0]);
            weekday_next  = {5'b00000, wday};
            hour_next     = to_bcd(up_data.dt.hour[6:0]);
            minute_next   = to_bcd(up_data.dt.minute[6:0]);
            second_next   = to_bcd(up_data.dt.second[6:0]);
            clock_ok_next = 1'b0;
            vres_next     = 1'b1;
        end
        else
        begin
            year_next     = 12'd0;
            month_next    = 8'd0;
            day_next      = 8'd0;
            weekday_next  = 8'd0;
            hour_next     = 8'd0;
            minute_next   = 8'd0;
            second_next   = 8'd0;
            clock_ok_next = 1'b0;
            vres_next     = 1'b0;
        end
    end

    assign up_ready = ~valid_reg | out_ready;

    // output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (up_ready)
            valid_reg <= up_valid;
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            year_reg     <= year_next;
            month_reg    <= month_next;
            day_reg      <= day_next;
            weekday_reg  <= weekday_next;
            hour_reg     <= hour_next;
            minute_reg   <= minute_next;
            second_reg   <= second_next;
            clock_ok_reg <= clock_ok_next;
            vres_reg     <= vres_next;
        end
    end

    assign out_valid   = valid_reg;
    assign year_out    = year_reg;
    assign month_out   = month_reg;
    assign day_out     = day_reg;
    assign weekday_out = weekday_reg;
    assign hour_out    = hour_reg;
    assign minute_out  = minute_reg;
    assign second_out  = second_reg;
    assign clock_ok    = clock_ok_reg;
    assign valid_res   = vres_reg;

endmodule

/* hw/rtl/rtc_datetime_bcd_codec.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtc_datetime_bcd_codec
// bcd rtc register bytes to decimal datetime and back, with calendar check
// ----------------------------------------------------------------------------
// usage:
//   one request on the input channel (in_valid / in_ready) carries op and the
//   seven datetime fields; op decode turns raw register bytes into decimal,
//   op encode checks a decimal datetime, computes the weekday (0 sunday) and
//   returns bcd register bytes. every request gives exactly one result on the
//   output channel (out_valid / out_ready).
//   pipeline: three register stages (unpack, check, pack); the accepting edge
//   loads unpack, the request then moves on to check and then to the pack
//   result register, whose load raises out_valid.
//   throughput: one request per cycle while out_ready stays high, set by the
//   three-stage pipeline with a valid bit per stage.
//   stall: when out_ready is low the result holds; each stage keeps taking
//   requests while it or a later stage is empty, so in_ready drops only once
//   all three stages are full.
//   reset: rst_n clears every stage valid bit; nothing else is kept.
// ----------------------------------------------------------------------------
module rtc_datetime_bcd_codec
    import rdc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        op,
    input  logic [11:0] year_in,
    input  logic [7:0]  month_in,
    input  logic [7:0]  day_in,
    input  logic [7:0]  weekday_in,
    input  logic [7:0]  hour_in,
    input  logic [7:0]  minute_in,
    input  logic [7:0]  second_in,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [11:0] year_out,
    output logic [7:0]  month_out,
    output logic [7:0]  day_out,
    output logic [7:0]  weekday_out,
    output logic [7:0]  hour_out,
    output logic [7:0]  minute_out,
    output logic [7:0]  second_out,
    output logic        clock_ok,
    output logic        valid_res
);

    logic     s1_valid;
    logic     s1_ready;
    rdc_dt_t  s1_data;
    logic     s2_valid;
    logic     s2_ready;
    rdc_chk_t s2_data;

    // stage 1: unpack
    rdc_unpack u_unpack (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .op         (op),
        .year_in    (year_in),
        .month_in   (month_in),
        .day_in     (day_in),
        .weekday_in (weekday_in),
        .hour_in    (hour_in),
        .minute_in  (minute_in),
        .second_in  (second_in),
        .dn_valid   (s1_valid),
        .dn_ready   (s1_ready),
        .dn_data    (s1_data)
    );

    // stage 2: check
    rdc_check u_check (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (s1_valid),
        .up_ready (s1_ready),
        .up_data  (s1_data),
        .dn_valid (s2_valid),
        .dn_ready (s2_ready),
        .dn_data  (s2_data)
    );

    // stage 3: pack and output register
    rdc_pack u_pack (
        .clk         (clk),
        .rst_n       (rst_n),
        .up_valid    (s2_valid),
        .up_ready    (s2_ready),
        .up_data     (s2_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .year_out    (year_out),
        .month_out   (month_out),
        .day_out     (day_out),
        .weekday_out (weekday_out),
        .hour_out    (hour_out),
        .minute_out  (minute_out),
        .second_out  (second_out),
        .clock_ok    (clock_ok),
        .valid_res   (valid_res)
    );

endmodule

/* hw/rtl/rdc_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdc_checker
// port-level assertions on the codec output channel
// ----------------------------------------------------------------------------
module rdc_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [11:0] year_out,
    input  logic [7:0]  month_out,
    input  logic [7:0]  day_out,
    input  logic [7:0]  weekday_out,
    input  logic [7:0]  hour_out,
    input  logic        valid_res
);

    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(year_out)
        && $stable(month_out) && $stable(day_out) && $stable(valid_res))
        else $error("stalled result changed");

    // valid year is a decimal 20xx or a bcd byte
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && valid_res |->
        (year_out >= 12'd2000 && year_out <= 12'd2099)
        || (year_out[11:8] == 4'd0 && year_out[7:4] <= 4'd9 && year_out[3:0] <= 4'd9))
        else $error("valid result with bad year");

    // valid result has a real weekday and hour
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && valid_res |-> weekday_out <= 8'd6 && hour_out <= 8'h23)
        else $error("valid result with bad weekday or hour");

    // valid result never has month or day zero
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && valid_res |-> month_out != 8'd0 && day_out != 8'd0)
        else $error("valid result with zero month or day");

endmodule

bind rtc_datetime_bcd_codec rdc_checker u_rdc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .year_out    (year_out),
    .month_out   (month_out),
    .day_out     (day_out),
    .weekday_out (weekday_out),
    .hour_out    (hour_out),
    .valid_res   (valid_res)
);

/* tb/sv/rtc_datetime_bcd_codec_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtc_datetime_bcd_codec_tb
// self-checking bench for the rtc datetime bcd codec: a directed table covers
// field extremes, leap days, bad bcd digits and every encode reject reason,
// then random requests (mostly well-formed dates with random junk in the
// masked register bits) run under random sender and receiver stalls. each
// result is compared field by field against a typed expectation or an in-bench calendar model.
// ----------------------------------------------------------------------------
module rtc_datetime_bcd_codec_tb;
    import rdc_pkg::*;

    localparam int RANDOM_REQUESTS = 650;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int HOLD_OFF_AT     = 130;
    localparam int HOLD_OFF_CYCLES = 200;
    localparam int DRAIN_CYCLES    = 10;

    // one request as driven on the input channel
    typedef struct packed {
        logic        op;
        logic [11:0] year;
        logic [7:0]  month;
        logic [7:0]  day;
        logic [7:0]  weekday;
        logic [7:0]  hour;
        logic [7:0]  minute;
        logic [7:0]  second;
    } dt_req_t;

    // one result as seen on the output channel
    typedef struct packed {
        logic [11:0] year;
        logic [7:0]  month;
        logic [7:0]  day;
        logic [7:0]  weekday;
        logic [7:0]  hour;
        logic [7:0]  minute;
        logic [7:0]  second;
        logic        clock_ok;
        logic        valid;
    } dt_res_t;

    // directed row, expectation typed in or left to the calendar model
    typedef struct packed {
        dt_req_t req;
        logic    typed;
        dt_res_t res;
    } dt_row_t;

    localparam dt_res_t ENCODE_REJECT = '0;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic        op;
    logic [11:0] year_in;
    logic [7:0]  month_in;
    logic [7:0]  day_in;
    logic [7:0]  weekday_in;
    logic [7:0]  hour_in;
    logic [7:0]  minute_in;
    logic [7:0]  second_in;
    logic        out_valid;
    logic        out_ready;
    logic [11:0] year_out;
    logic [7:0]  month_out;
    logic [7:0]  day_out;
    logic [7:0]  weekday_out;
    logic [7:0]  hour_out;
    logic [7:0]  minute_out;
    logic [7:0]  second_out;
    logic        clock_ok;
    logic        valid_res;

    dt_res_t datetime_expect_q[$];
    dt_row_t directed_rows[$];
    int      sent_count;
    int      taken_count;
    int      mismatch_count;
    int      cycle_count;

    rtc_datetime_bcd_codec i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .op          (op),
        .year_in     (year_in),
        .month_in    (month_in),
        .day_in      (day_in),
        .weekday_in  (weekday_in),
        .hour_in     (hour_in),
        .minute_in   (minute_in),
        .second_in   (second_in),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .year_out    (year_out),
        .month_out   (month_out),
        .day_out     (day_out),
        .weekday_out (weekday_out),
        .hour_out    (hour_out),
        .minute_out  (minute_out),
        .second_out  (second_out),
        .clock_ok    (clock_ok),
        .valid_res   (valid_res)
    );

    // calendar arithmetic
    function automatic int bcd_value(input logic [7:0] b);
        return int'(b[7:4]) * 10 + int'(b[3:0]);
    endfunction

    function automatic logic [7:0] bcd_byte(input int d);
        return {4'((d / 10) % 10), 4'(d % 10)};
    endfunction

    function automatic bit is_leap(input int y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int month_length(input int y, input int m);
        case (m)
            1, 3, 5, 7, 8, 10, 12: return 31;
            4, 6, 9, 11:           return 30;
            2:                     return is_leap(y) ? 29 : 28;
            default:               return 0;
        endcase
    endfunction

    function automatic bit calendar_ok(input int y, input int mo, input int d, input int wd,
                                       input int h, input int mi, input int s);
        if (y < int'(YEAR_BASE) || y > int'(YEAR_MAX)) return 1'b0;
        if (mo < 1 || mo > int'(MON_MAX)) return 1'b0;
        if (d < 1 || d > month_length(y, mo)) return 1'b0;
        if (wd > int'(WDAY_MAX) || h > int'(HOUR_MAX)) return 1'b0;
        if (mi > int'(MIN_MAX) || s > int'(SEC_MAX)) return 1'b0;
        return 1'b1;
    endfunction

    // zeller, 0 sunday; jan and feb count as months 13 and 14 of the prior year
    function automatic int weekday_of(input int y, input int m, input int d);
        int k;
        int j;
        int h;
        if (m < 3)
        begin
            m = m + 12;
            y = y - 1;
        end
        k = y % 100;
        j = y / 100;
        h = (d + (13 * (m + 1)) / 5 + k + k / 4 + j / 4 + 5 * j) % 7;
        return (h + 6) % 7;
    endfunction

    // expected result of one request
    function automatic dt_res_t predict_datetime(input dt_req_t r);
        dt_res_t res;
        int      y;
        int      mo;
        int      d;
        int      wd;
        int      h;
        int      mi;
        int      s;
        res = '0;
        if (r.op == OP_DECODE)
        begin
            y  = int'(YEAR_BASE) + bcd_value(r.year[7:0]);
            mo = bcd_value(r.month & MON_MASK);
            d  = bcd_value(r.day & DAY_MASK);
            wd = bcd_value(r.weekday & WDAY_MASK);
            h  = bcd_value(r.hour & HOUR_MASK);
            mi = bcd_value(r.minute & MIN_MASK);
            s  = bcd_value(r.second & SEC_MASK);
            res.year     = 12'(y);
            res.month    = 8'(mo);
            res.day      = 8'(d);
            res.weekday  = 8'(wd);
            res.hour     = 8'(h);
            res.minute   = 8'(mi);
            res.second   = 8'(s);
            res.clock_ok = !r.second[OSC_STOP_BIT];
            res.valid    = calendar_ok(y, mo, d, wd, h, mi, s);
        end
        else if (calendar_ok(int'(r.year), int'(r.month), int'(r.day), int'(r.weekday),
                             int'(r.hour), int'(r.minute), int'(r.second)))
        begin
            res.year    = {4'h0, bcd_byte(int'(r.year) % 100)};
            res.month   = bcd_byte(int'(r.month));
            res.day     = bcd_byte(int'(r.day));
            res.weekday = bcd_byte(weekday_of(int'(r.year), int'(r.month), int'(r.day)));
            res.hour    = bcd_byte(int'(r.hour));
            res.minute  = bcd_byte(int'(r.minute));
            res.second  = bcd_byte(int'(r.second));
            res.valid   = 1'b1;
        end
        return res;
    endfunction

    function automatic dt_req_t req_of(input logic o, input logic [11:0] y,
                                       input logic [7:0] mo, input logic [7:0] d,
                                       input logic [7:0] wd, input logic [7:0] h,
                                       input logic [7:0] mi, input logic [7:0] s);
        return '{o, y, mo, d, wd, h, mi, s};
    endfunction

    function automatic dt_res_t res_of(input logic [11:0] y, input logic [7:0] mo,
                                       input logic [7:0] d, input logic [7:0] wd,
                                       input logic [7:0] h, input logic [7:0] mi,
                                       input logic [7:0] s, input logic ok, input logic v);
        return '{y, mo, d, wd, h, mi, s, ok, v};
    endfunction

    task automatic add_row(input dt_req_t r, input logic typed, input dt_res_t e);
        directed_rows.push_back('{r, typed, e});
    endtask

    // random request: mostly a real date, some with one field broken, some noise
    function automatic dt_req_t random_request();
        dt_req_t    r;
        int         kind;
        int         y;
        int         mo;
        int         d;
        int         wd;
        int         h;
        int         mi;
        int         s;
        int         dim;
        logic [7:0] ybyte;
        logic [7:0] mo_bcd;
        logic [7:0] d_bcd;
        logic [7:0] wd_bcd;
        logic [7:0] h_bcd;
        logic [7:0] mi_bcd;
        logic [7:0] s_bcd;
        kind = $urandom_range(0, 19);
        r.op = 1'($urandom_range(0, 1));
        y    = $urandom_range(2000, 2099);
        mo   = $urandom_range(1, 12);
        dim  = month_length(y, mo);
        d    = $urandom_range(1, dim);
        wd   = $urandom_range(0, 6);
        h    = $urandom_range(0, 23);
        mi   = $urandom_range(0, 59);
        s    = $urandom_range(0, 59);
        if (kind >= 14 && kind <= 16)
        begin
            case ($urandom_range(0, 6))
                0: d  = ($urandom_range(0, 1) != 0) ? 0 : dim + 1;
                1: mo = ($urandom_range(0, 1) != 0) ? 0 : 13;
                2: h  = 24;
                3: mi = 60;
                4: s  = 60;
                5: wd = 7;
                default: y = ($urandom_range(0, 1) != 0) ? 1999 : 2100;
            endcase
        end
        if (kind >= 17)
        begin
            r.year    = 12'($urandom_range(0, 4095));
            r.month   = 8'($urandom_range(0, 255));
            r.day     = 8'($urandom_range(0, 255));
            r.weekday = 8'($urandom_range(0, 255));
            r.hour    = 8'($urandom_range(0, 255));
            r.minute  = 8'($urandom_range(0, 255));
            r.second  = 8'($urandom_range(0, 255));
        end
        else if (r.op == OP_ENCODE)
        begin
            r.year    = 12'(y);
            r.month   = 8'(mo);
            r.day     = 8'(d);
            r.weekday = 8'(wd);
            r.hour    = 8'(h);
            r.minute  = 8'(mi);
            r.second  = 8'(s);
        end
        else
        begin
            // register bytes with random junk in the bits the block masks off
            if (y >= 2000 && y <= 2099)
                ybyte = bcd_byte(y - 2000);
            else
                ybyte = {4'hA, 4'($urandom_range(0, 9))};
            mo_bcd    = bcd_byte(mo);
            d_bcd     = bcd_byte(d);
            wd_bcd    = bcd_byte(wd);
            h_bcd     = bcd_byte(h);
            mi_bcd    = bcd_byte(mi);
            s_bcd     = bcd_byte(s);
            r.year    = {4'($urandom_range(0, 15)), ybyte};
            r.month   = {3'($urandom_range(0, 7)), mo_bcd[4:0]};
            r.day     = {2'($urandom_range(0, 3)), d_bcd[5:0]};
            r.weekday = {5'($urandom_range(0, 31)), wd_bcd[2:0]};
            r.hour    = {2'($urandom_range(0, 3)), h_bcd[5:0]};
            r.minute  = {1'($urandom_range(0, 1)), mi_bcd[6:0]};
            r.second  = {1'($urandom_range(0, 1)), s_bcd[6:0]};
        end
        return r;
    endfunction

    // offer one request, hold it until taken, then queue its expectation
    task automatic send_request(input dt_req_t r, input dt_res_t e);
        int gap;
        gap = ((sent_count / 40) % 3 == 0) ? 0 : $urandom_range(0, 16);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        op         <= r.op;
        year_in    <= r.year;
        month_in   <= r.month;
        day_in     <= r.day;
        weekday_in <= r.weekday;
        hour_in    <= r.hour;
        minute_in  <= r.minute;
        second_in  <= r.second;
        in_valid   <= 1'b1;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
        datetime_expect_q.push_back(e);
        sent_count++;
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run-length guard
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d results outstanding", $time,
                     datetime_expect_q.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // receiver: random stalls per result, one long hold-off to back up the pipe
    initial
    begin
        int stall;
        out_ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (taken_count == HOLD_OFF_AT)
                stall = HOLD_OFF_CYCLES;
            else if ((taken_count / 50) % 2 == 0)
                stall = 0;
            else
                stall = $urandom_range(0, 16);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            @(negedge clk);
        end
    end

    // result checker
    always @(posedge clk)
    begin
        dt_res_t want;
        dt_res_t got;
        if (rst_n && out_valid && out_ready)
        begin
            got = '{year_out, month_out, day_out, weekday_out, hour_out, minute_out,
                    second_out, clock_ok, valid_res};
            if (datetime_expect_q.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %h", $time, got);
                mismatch_count++;
            end
            else
            begin
                want = datetime_expect_q.pop_front();
                check_field("year", want.year, got.year);
                check_field("month", want.month, got.month);
                check_field("day", want.day, got.day);
                check_field("weekday", want.weekday, got.weekday);
                check_field("hour", want.hour, got.hour);
                check_field("minute", want.minute, got.minute);
                check_field("second", want.second, got.second);
                check_field("clock_ok", want.clock_ok, got.clock_ok);
                check_field("valid_res", want.valid, got.valid);
            end
            taken_count++;
        end
    end

    // stimulus
    initial
    begin
        dt_req_t r;
        dt_res_t e;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        op         = OP_DECODE;
        year_in    = '0;
        month_in   = '0;
        day_in     = '0;
        weekday_in = '0;
        hour_in    = '0;
        minute_in  = '0;
        second_in  = '0;

        // decode: all zero, first and last valid instants, all ones
        add_row(req_of(OP_DECODE, 12'h000, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00), 1'b1,
                res_of(12'd2000, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1, 1'b0));
        add_row(req_of(OP_DECODE, 12'h000, 8'h01, 8'h01, 8'h06, 8'h00, 8'h00, 8'h00), 1'b1,
                res_of(12'd2000, 8'd1, 8'd1, 8'd6, 8'd0, 8'd0, 8'd0, 1'b1, 1'b1));
        add_row(req_of(OP_DECODE, 12'h099, 8'h12, 8'h31, 8'h06, 8'h23, 8'h59, 8'hD9), 1'b1,
                res_of(12'd2099, 8'd12, 8'd31, 8'd6, 8'd23, 8'd59, 8'd59, 1'b0, 1'b1));
        add_row(req_of(OP_DECODE, 12'hFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF), 1'b1,
                res_of(12'd2165, 8'd25, 8'd45, 8'd7, 8'd45, 8'd85, 8'd85, 1'b0, 1'b0));
        // decode: leap days, year past 2099, short month, bad bcd digit, junk bits
        add_row(req_of(OP_DECODE, 12'h024, 8'h02, 8'h29, 8'h04, 8'h12, 8'h30, 8'h45), 1'b0, '0);
        add_row(req_of(OP_DECODE, 12'h023, 8'h02, 8'h29, 8'h03, 8'h12, 8'h30, 8'h45), 1'b0, '0);
        add_row(req_of(OP_DECODE, 12'h000, 8'h02, 8'h29, 8'h02, 8'h08, 8'h15, 8'h00), 1'b0, '0);
        add_row(req_of(OP_DECODE, 12'h0A0, 8'h01, 8'h01, 8'h01, 8'h00, 8'h00, 8'h00), 1'b0, '0);
        add_row(req_of(OP_DECODE, 12'h021, 8'h04, 8'h31, 8'h05, 8'h10, 8'h10, 8'h10), 1'b0, '0);
        add_row(req_of(OP_DECODE, 12'h050, 8'h06, 8'h15, 8'h01, 8'h11, 8'h5A, 8'h20), 1'b0, '0);
        add_row(req_of(OP_DECODE, 12'hF25, 8'hE7, 8'hC9, 8'hF8, 8'hC7, 8'hB0, 8'h15), 1'b0, '0);
        // encode: all zero, first valid instant, last valid instant
        add_row(req_of(OP_ENCODE, 12'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0), 1'b1,
                ENCODE_REJECT);
        add_row(req_of(OP_ENCODE, 12'd2000, 8'd1, 8'd1, 8'd0, 8'd0, 8'd0, 8'd0), 1'b1,
                res_of(12'h000, 8'h01, 8'h01, 8'h06, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1));
        add_row(req_of(OP_ENCODE, 12'd2099, 8'd12, 8'd31, 8'd6, 8'd23, 8'd59, 8'd59), 1'b0, '0);
        // encode: every reject reason gives an all-zero result, and a leap day is accepted
        add_row(req_of(OP_ENCODE, 12'd1999, 8'd6, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1), 1'b1,
                ENCODE_REJECT);
        add_row(req_of(OP_ENCODE, 12'd2100, 8'd6, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1), 1'b1,
                ENCODE_REJECT);
        add_row(req_of(OP_ENCODE, 12'd2030, 8'd13, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1), 1'b1,
                ENCODE_REJECT);
        add_row(req_of(OP_ENCODE, 12'd2030, 8'd6, 8'd0, 8'd1, 8'd1, 8'd1, 8'd1), 1'b1,
                ENCODE_REJECT);
        add_row(req_of(OP_ENCODE, 12'd2030, 8'd6, 8'd1, 8'd7, 8'd1, 8'd1, 8'd1), 1'b1,
                ENCODE_REJECT);
        add_row(req_of(OP_ENCODE, 12'd2030, 8'd6, 8'd1, 8'd1, 8'd24, 8'd1, 8'd1), 1'b1,
                ENCODE_REJECT);
        add_row(req_of(OP_ENCODE, 12'd2030, 8'd6, 8'd1, 8'd1, 8'd1, 8'd60, 8'd1), 1'b1,
                ENCODE_REJECT);
        add_row(req_of(OP_ENCODE, 12'd2030, 8'd6, 8'd1, 8'd1, 8'd1, 8'd1, 8'd60), 1'b1,
                ENCODE_REJECT);
        add_row(req_of(OP_ENCODE, 12'd2023, 8'd2, 8'd29, 8'd1, 8'd1, 8'd1, 8'd1), 1'b1,
                ENCODE_REJECT);
        add_row(req_of(OP_ENCODE, 12'd2024, 8'd2, 8'd29, 8'd0, 8'd9, 8'd41, 8'd7), 1'b0, '0);
        add_row(req_of(OP_ENCODE, 12'hFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF), 1'b1,
                ENCODE_REJECT);

        // reset
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed table
        foreach (directed_rows[i])
        begin
            e = directed_rows[i].typed ? directed_rows[i].res :
                                         predict_datetime(directed_rows[i].req);
            send_request(directed_rows[i].req, e);
        end

        // random requests
        repeat (RANDOM_REQUESTS)
        begin
            r = random_request();
            send_request(r, predict_datetime(r));
        end
        in_valid <= 1'b0;

        // drain
        while (datetime_expect_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/rdc_pkg.sv
hw/rtl/rdc_unpack.sv
hw/rtl/rdc_check.sv
hw/rtl/rdc_pack.sv
hw/rtl/rtc_datetime_bcd_codec.sv
hw/rtl/rdc_checker.sv
tb/sv/rtc_datetime_bcd_codec_tb.sv
